>>> src/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg
// shared types, constants and helpers of the coin change way counter
// ----------------------------------------------------------------------------
package ccw_pkg;

  // largest amount the ways table covers
  localparam int unsigned AmountLimit = 4095;
  localparam int unsigned Depth       = AmountLimit + 1;
  localparam int unsigned AddrW       = $clog2(Depth);

  localparam int unsigned TgtW  = 12;
  localparam int unsigned CoinW = 12;
  localparam int unsigned WaysW = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [WaysW-1:0] ways_t;
  typedef logic [TgtW-1:0]  tgt_t;

  typedef struct packed {
    logic [CoinW-1:0] coin_value;
    logic             last_coin;
  } in_t;

  typedef struct packed {
    ways_t ways_count;
    logic  overflowed;
  } out_t;

  // one write port, two read ports
  typedef struct packed {
    logic  we;
    addr_t waddr;
    ways_t wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_FINAL,
    ST_FETCH,
    ST_RESULT
  } state_e;

  // target clamped to the table range
  function automatic addr_t eff_target(tgt_t t);
    if (32'(t) > AmountLimit) return addr_t'(AmountLimit);
    return addr_t'(t);
  endfunction

endpackage

>>> src/ccw_ram.sv
// ----------------------------------------------------------------------------
// ccw_ram
// ways table storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module ccw_ram (
  input  logic              clk_i,
  input  ccw_pkg::ram_req_t req_i,
  output ccw_pkg::ways_t    rdata_a_o,
  output ccw_pkg::ways_t    rdata_b_o
);

  ccw_pkg::ways_t mem [ccw_pkg::Depth];
  ccw_pkg::ways_t rdata_a_q;
  ccw_pkg::ways_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_a_q <= mem[req_i.raddr_a];
    rdata_b_q <= mem[req_i.raddr_b];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/ccw_ctrl.sv
// ----------------------------------------------------------------------------
// ccw_ctrl
// sequencer: table clearing, per-coin read-modify-write sweep, result fetch
// ----------------------------------------------------------------------------
module ccw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccw_pkg::tgt_t      tgt_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ccw_pkg::in_t       in_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output ccw_pkg::out_t      res_o,
  output ccw_pkg::ram_req_t  ram_req_o,
  input  ccw_pkg::ways_t     rdata_a_i,
  input  ccw_pkg::ways_t     rdata_b_i
);

  ccw_pkg::state_e state_q, state_d;
  ccw_pkg::addr_t  idx_q, idx_d;
  ccw_pkg::addr_t  coin_q, coin_d;
  ccw_pkg::addr_t  tgt_q, tgt_d;
  ccw_pkg::addr_t  wr_addr_q, wr_addr_d;
  ccw_pkg::ways_t  fwd_data_q, fwd_data_d;
  logic            last_q, last_d;
  logic            ovf_q, ovf_d;
  logic            pend_q, pend_d;
  logic            fwd_q, fwd_d;

  logic            accept;
  logic            skip;
  ccw_pkg::addr_t  tgt_eff;
  ccw_pkg::ways_t  lo_val;
  logic [ccw_pkg::WaysW:0] sum;

  assign accept  = in_valid_i && in_ready_o;
  assign tgt_eff = ccw_pkg::eff_target(tgt_i);
  assign skip    = (in_i.coin_value == '0) || (32'(in_i.coin_value) > 32'(tgt_eff));

  // second stage of the sweep: add and saturate
  assign lo_val = fwd_q ? fwd_data_q : rdata_b_i;
  assign sum    = {1'b0, rdata_a_i} + {1'b0, lo_val};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ccw_pkg::ST_CLEAR: begin
        if (idx_q == ccw_pkg::addr_t'(ccw_pkg::AmountLimit)) state_d = ccw_pkg::ST_IDLE;
      end
      ccw_pkg::ST_IDLE: begin
        if (accept) begin
          if (!skip) state_d = ccw_pkg::ST_SWEEP;
          else if (in_i.last_coin) state_d = ccw_pkg::ST_FETCH;
        end
      end
      ccw_pkg::ST_SWEEP: begin
        if (idx_q == tgt_q) state_d = ccw_pkg::ST_FINAL;
      end
      ccw_pkg::ST_FINAL: begin
        state_d = last_q ? ccw_pkg::ST_FETCH : ccw_pkg::ST_IDLE;
      end
      ccw_pkg::ST_FETCH: begin
        state_d = ccw_pkg::ST_RESULT;
      end
      ccw_pkg::ST_RESULT: begin
        if (res_ready_i) state_d = ccw_pkg::ST_CLEAR;
      end
      default: state_d = ccw_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    idx_d      = idx_q;
    coin_d     = coin_q;
    tgt_d      = tgt_q;
    last_d     = last_q;
    ovf_d      = ovf_q;
    pend_d     = 1'b0;
    wr_addr_d  = wr_addr_q;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_req_o  = '0;

    // write back of the previous read, saturating
    if (pend_q) begin
      ram_req_o.we    = 1'b1;
      ram_req_o.waddr = wr_addr_q;
      ram_req_o.wdata = sum[ccw_pkg::WaysW] ? '1 : sum[ccw_pkg::WaysW-1:0];
      if (sum[ccw_pkg::WaysW]) ovf_d = 1'b1;
    end

    unique case (state_q)
      ccw_pkg::ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = (idx_q == '0) ? ccw_pkg::ways_t'(1) : '0;
        idx_d = (idx_q == ccw_pkg::addr_t'(ccw_pkg::AmountLimit)) ? '0 : idx_q + 1'b1;
      end
      ccw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          tgt_d  = tgt_eff;
          last_d = in_i.last_coin;
          coin_d = ccw_pkg::addr_t'(in_i.coin_value);
          idx_d  = ccw_pkg::addr_t'(in_i.coin_value);
        end
      end
      ccw_pkg::ST_SWEEP: begin
        ram_req_o.raddr_a = idx_q;
        ram_req_o.raddr_b = idx_q - coin_q;
        pend_d    = 1'b1;
        wr_addr_d = idx_q;
        idx_d     = idx_q + 1'b1;
      end
      ccw_pkg::ST_FINAL: begin
        ram_req_o.raddr_a = tgt_q;
      end
      ccw_pkg::ST_FETCH: begin
        ram_req_o.raddr_a = tgt_q;
      end
      ccw_pkg::ST_RESULT: begin
        ram_req_o.raddr_a = tgt_q;
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          ovf_d = 1'b0;
          idx_d = '0;
        end
      end
      default: ;
    endcase

    // entry just read at the low address is being written this cycle
    fwd_d      = ram_req_o.we && (ram_req_o.waddr == ram_req_o.raddr_b);
    fwd_data_d = ram_req_o.wdata;
  end

  assign res_o.ways_count = rdata_a_i;
  assign res_o.overflowed = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccw_pkg::ST_CLEAR;
      idx_q   <= '0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coin_q     <= coin_d;
    tgt_q      <= tgt_d;
    wr_addr_q  <= wr_addr_d;
    fwd_data_q <= fwd_data_d;
  end

endmodule

>>> src/coin_change_way_counter.sv
// ----------------------------------------------------------------------------
// coin_change_way_counter
// counts coin combinations summing to a configured target amount
// ----------------------------------------------------------------------------
// usage:
//   cfg_we_i/cfg_wdata_i write the target amount; write it only while idle
//   input channel (in_valid_i/in_ready_o/in_i) takes one coin value per
//   transfer; last_coin closes the set and produces one result transfer on
//   the output channel (out_valid_o/out_ready_i/out_o)
//   each coin c against target t sweeps the ways table once, one entry per
//   cycle through the single table memory, when c is in range; a coin of
//   zero or above the target is taken without a sweep
//   a last coin leads on to a fetch of the count, then all AmountLimit + 1
//   entries (4096) of the table are cleared before the next coin is taken
//   after reset the same clearing pass runs; config writes are still taken
//   a result waits in the output register while the receiver stalls; the
//   next set may run meanwhile, and its result holds in the sequencer
//   until the register frees up
// ----------------------------------------------------------------------------
module coin_change_way_counter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  ccw_pkg::tgt_t cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ccw_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ccw_pkg::out_t out_o
);

  // target amount register
  ccw_pkg::tgt_t     tgt_q;

  // sequencer to output register
  logic              res_valid;
  logic              res_ready;
  ccw_pkg::out_t     res;

  // table memory port
  ccw_pkg::ram_req_t ram_req;
  ccw_pkg::ways_t    rdata_a;
  ccw_pkg::ways_t    rdata_b;

  // output register
  logic              out_valid_q, out_valid_d;
  ccw_pkg::out_t     out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
    end else if (cfg_we_i) begin
      tgt_q <= cfg_wdata_i;
    end
  end

  ccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tgt_i       (tgt_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  ccw_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // the register takes a new result when empty or being drained this cycle
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // a closing coin holds off the next transfer
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_i.last_coin) |=> !in_ready_o)
    else $error("input taken right after a last coin");

  // no table write may be pending while a new coin is taken
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> !in_ready_o)
    else $error("table write while accepting a coin");

  // a result offered to a full output register stays offered until taken
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result withdrawn before the output register took it");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks coin_change_way_counter against a ways table kept alongside the dut
// ----------------------------------------------------------------------------
// coin sets are fed over the input channel, and the tally class replays each
// accepted coin on its own ways table, queueing a count for every last coin.
// counts coming out of the dut are compared field by field in arrival order.
// the target is only rewritten once the dut has drained and finished its
// sweep or clearing pass. a directed part is followed by random coin sets
// under three idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  // longest sweep plus a full clearing pass, with margin
  localparam int unsigned SettleCycles  = 2 * ccw_pkg::Depth + 16;
  // no transfer for this long means the dut has hung
  localparam int unsigned WatchdogLimit = 10 * ccw_pkg::Depth;
  localparam int unsigned RandomCoins   = 115;
  localparam int unsigned ReportLimit   = 10;

  // ways table and expected counts for the coin sets seen so far
  class coin_ways_tally;
    ccw_pkg::ways_t ways_tbl [ccw_pkg::Depth];
    logic           ovf_seen;
    ccw_pkg::tgt_t  target;
    ccw_pkg::out_t  counts_due [$];
    int unsigned    mismatches;

    function new();
      target     = '0;
      mismatches = 0;
      clear_ways();
    endfunction

    function void clear_ways();
      foreach (ways_tbl[i]) ways_tbl[i] = '0;
      ways_tbl[0] = ccw_pkg::ways_t'(1);
      ovf_seen    = 1'b0;
    endfunction

    // one ascending sweep per coin; a last coin queues the count at the target
    function void note_coin(ccw_pkg::in_t item);
      int unsigned              t;
      logic [ccw_pkg::WaysW:0]  sum;
      ccw_pkg::out_t            due;
      t = (target > ccw_pkg::AmountLimit) ? ccw_pkg::AmountLimit : target;
      if (item.coin_value != 0 && item.coin_value <= t) begin
        for (int unsigned j = item.coin_value; j <= t; j++) begin
          sum = {1'b0, ways_tbl[j]} + {1'b0, ways_tbl[j - item.coin_value]};
          if (sum[ccw_pkg::WaysW]) begin
            ways_tbl[j] = '1;
            ovf_seen    = 1'b1;
          end else begin
            ways_tbl[j] = sum[ccw_pkg::WaysW-1:0];
          end
        end
      end
      if (item.last_coin) begin
        due.ways_count = ways_tbl[t];
        due.overflowed = ovf_seen;
        counts_due.push_back(due);
        clear_ways();
      end
    endfunction

    function void check_count(ccw_pkg::out_t got);
      ccw_pkg::out_t due;
      if (counts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected count: ways %0d overflow %0b", got.ways_count,
                   got.overflowed);
      end else begin
        due = counts_due.pop_front();
        if (got.ways_count !== due.ways_count || got.overflowed !== due.overflowed) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("count mismatch: expected ways %0d overflow %0b, %s %0d overflow %0b",
                     due.ways_count, due.overflowed, "got ways", got.ways_count,
                     got.overflowed);
        end
      end
    endfunction

    function int unsigned pending();
      return counts_due.size();
    endfunction
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  ccw_pkg::tgt_t cfg_wdata_i = '0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  ccw_pkg::in_t  in_i        = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  ccw_pkg::out_t out_o;

  // idle percentages of the sender and the receiver, set by the stimulus
  int unsigned tx_idle_pct  = 34;
  int unsigned rx_idle_pct  = 64;
  int unsigned quiet_cycles = 0;

  coin_ways_tally tally;

  coin_change_way_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stalls at random, one roll per cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result check and watchdog; values sampled here are the ones before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) tally.check_count(out_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("testbench NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one coin transfer; valid stays high after the transfer so that a following
  // coin with no gap keeps it high without a drop
  task automatic send_coin(logic [ccw_pkg::CoinW-1:0] coin, logic last);
    ccw_pkg::in_t item;
    item.coin_value = coin;
    item.last_coin  = last;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tally.note_coin(item);
  endtask

  // wait for every due count, then for any sweep or clearing pass to finish
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tally.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_target(ccw_pkg::tgt_t target);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= target;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tally.target = target;
  endtask

  initial begin
    int unsigned                 sent;
    int unsigned                 sets;
    int unsigned                 len;
    ccw_pkg::tgt_t               tgt;
    logic [ccw_pkg::CoinW-1:0]   coin;
    logic                        last;

    tally = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // target zero: count is one whatever the coins, zero coin still answers
    write_target('0);
    send_coin('0, 1'b1);
    send_coin('1, 1'b1);
    send_coin(12'd1, 1'b0);
    send_coin(12'd2, 1'b1);

    // small target: coins 1, 2, 5 give ten ways; coin above target and zero coin
    write_target(12'd10);
    send_coin(12'd1, 1'b0);
    send_coin(12'd2, 1'b0);
    send_coin(12'd5, 1'b1);
    send_coin(12'd11, 1'b0);
    send_coin(12'd3, 1'b0);
    send_coin('0, 1'b0);
    send_coin(12'd10, 1'b1);

    // full-range target, alternating bit patterns on the coin
    write_target('1);
    send_coin('1, 1'b0);
    send_coin(12'd1, 1'b1);
    send_coin(12'hAAA, 1'b0);
    send_coin(12'h555, 1'b1);

    // many small coins against a large target saturate the count
    write_target(12'd1000);
    for (int c = 1; c <= 6; c++) send_coin(ccw_pkg::CoinW'(c), c == 6);

    // target lowered in the middle of a set
    write_target(12'd20);
    send_coin(12'd3, 1'b0);
    send_coin(12'd4, 1'b0);
    write_target(12'd7);
    send_coin(12'd1, 1'b1);

    // random coin sets, each phase under one target
    sent = 0;
    while (sent < RandomCoins) begin
      if (sent < RandomCoins / 3) begin
        tx_idle_pct = 34;
        rx_idle_pct = 64;
      end else if (sent < 2 * RandomCoins / 3) begin
        tx_idle_pct = 64;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // mostly small targets keep sweeps short; a few at the top of the range
      case ($urandom_range(0, 7))
        0:       tgt = '1;
        1:       tgt = ccw_pkg::tgt_t'($urandom);
        default: tgt = ccw_pkg::tgt_t'($urandom_range(0, 300));
      endcase
      write_target(tgt);
      sets = $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0:       coin = '0;
            1:       coin = ccw_pkg::CoinW'($urandom);
            2:       coin = ccw_pkg::CoinW'(tgt + $urandom_range(1, 64));
            default: coin = ccw_pkg::CoinW'($urandom_range(1, (tgt == 0) ? 1 : tgt));
          endcase
          // now and then the phase ends with the set still open, so the next
          // target takes over mid-set
          last = (k == len - 1) && !(s == sets - 1 && $urandom_range(0, 5) == 0);
          send_coin(coin, last);
          sent++;
        end
      end
    end

    wait_drained();
    if (tally.mismatches == 0 && tally.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
